/* design/ksr_pkg.sv */
// Shared types, constants and stencil coefficient tables for the stencil residual block.
// Used by ks_stencil_residual, ksr_front, ksr_back and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ksr_pkg;

  localparam int CELLS      = 49;
  localparam int WIN_DIM    = 7;
  localparam int ROWS_LIMIT = 4096;

  // accumulator picked by one step of the stencil sequencer
  typedef enum logic [1:0] {TGT_HYP, TGT_LAP, TGT_GX, TGT_GY} ksr_tgt_t;

  // wide multiply operations, in the order the back end runs them
  typedef enum logic [2:0] {OP_AXG, OP_SQX, OP_AYG, OP_SQY, OP_LAP, OP_HYP} ksr_op_t;

  typedef struct packed {
    logic signed [31:0] coef;
    ksr_tgt_t           tgt;
    logic               more;
  } ksr_term_t;

  // coefficients, 24 fraction bits
  function automatic logic signed [31:0] ksr_hyp_coef(input logic [1:0] dr,
                                                      input logic [1:0] dc);
    logic signed [31:0] v;
    case ({dr, dc})
      4'h0:    v = 32'sd561829610;
      4'h1:    v = -32'sd246065835;
      4'h2:    v = 32'sd47255825;
      4'h3:    v = -32'sd3811121;
      4'h4:    v = -32'sd246065835;
      4'h5:    v = 32'sd75497472;
      4'h6:    v = -32'sd7549747;
      4'h7:    v = 32'sd559241;
      4'h8:    v = 32'sd47255825;
      4'h9:    v = -32'sd7549747;
      4'ha:    v = 32'sd754975;
      4'hb:    v = -32'sd55924;
      4'hc:    v = -32'sd3811121;
      4'hd:    v = 32'sd559241;
      4'he:    v = -32'sd55924;
      4'hf:    v = 32'sd4143;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] ksr_lap_coef(input logic [1:0] d);
    logic signed [31:0] v;
    case (d)
      2'd0:    v = -32'sd91342620;
      2'd1:    v = 32'sd25165824;
      2'd2:    v = -32'sd2516582;
      2'd3:    v = 32'sd186414;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] ksr_grad_coef(input logic [1:0] d);
    logic signed [31:0] v;
    case (d)
      2'd1:    v = 32'sd12582912;
      2'd2:    v = -32'sd2516582;
      2'd3:    v = 32'sd279620;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Term for window cell (r, c) and sub-step sub. Every cell has a hyper-Laplacian
  // term; cells on the centre row or column add a Laplacian term and, off centre,
  // a gradient term.
  function automatic ksr_term_t ksr_term(input logic [2:0] r, input logic [2:0] c,
                                         input logic [1:0] sub);
    ksr_term_t t;
    logic [2:0] dr3, dc3;
    logic [1:0] dr, dc;
    logic on_axis, centre;
    dr3     = (r > 3'd3) ? r - 3'd3 : 3'd3 - r;
    dc3     = (c > 3'd3) ? c - 3'd3 : 3'd3 - c;
    dr      = dr3[1:0];
    dc      = dc3[1:0];
    on_axis = (r == 3'd3) || (c == 3'd3);
    centre  = (r == 3'd3) && (c == 3'd3);
    t.coef  = '0;
    t.tgt   = TGT_HYP;
    t.more  = 1'b0;
    case (sub)
      2'd0: begin
        t.coef = ksr_hyp_coef(dr, dc);
        t.more = on_axis;
      end
      2'd1: begin
        t.coef = ksr_lap_coef(dr + dc);
        t.tgt  = TGT_LAP;
        t.more = !centre;
      end
      2'd2: begin
        if (r == 3'd3) begin
          t.tgt  = TGT_GX;
          t.coef = (c > 3'd3) ? ksr_grad_coef(dc) : -ksr_grad_coef(dc);
        end else begin
          t.tgt  = TGT_GY;
          t.coef = (r > 3'd3) ? ksr_grad_coef(dr) : -ksr_grad_coef(dr);
        end
      end
      default: begin
        t.coef = '0;
      end
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

/* design/ks_stencil_residual.sv */
// Kuramoto-Sivashinsky stencil residual over a streamed, haloed tile.
// Uses ksr_pkg, ksr_front, ksr_queue and ksr_back.
//
// Usage: stream tile_rows+6 rows of tile_cols+6 samples in raster order on
// sample/sample_valid; sample_stall holds the sender off. Each sample whose 7x7
// window is complete (an interior point) yields one residual with last set on the
// tile's final interior point; the receiver takes results with result_valid and
// result_stall. Registers are written on cfg_valid/cfg_data/cfg_index, cfg_ready is
// always high; write them only while the block is idle.
// The front end reads the line buffer for each sample, then updates it, and for an
// interior point also pushes the window to the queue. Per point the back end runs
// a queue pop, 74 steps of the shared stencil MAC, one gradient rounding step, six
// 64x64 gain products on one 32x32 multiplier, then sum, rounding and output.
// A two-entry queue lets the front end keep reading while the back end works.
// A stalled receiver holds the result register; the queue fills and then
// sample_stall rises. Reset clears counters and window and sets the gains and tile size to defaults;
// the line buffers need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module ks_stencil_residual import ksr_pkg::*; #(
  parameter int MAX_TILE_COLS = 256,
  parameter int SAMPLE_BITS   = 18
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [3:0]                    cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic signed [63:0]                 residual,
  output logic                               last
);

  localparam int COL_W = $clog2(MAX_TILE_COLS + 6);
  localparam int QW    = CELLS * SAMPLE_BITS + 1;

  localparam logic [3:0] REG_G2   = 4'd0;
  localparam logic [3:0] REG_G4   = 4'd1;
  localparam logic [3:0] REG_COLS = 4'd2;
  localparam logic [3:0] REG_ROWS = 4'd3;

  logic [16:0]      second_order_gain;
  logic [31:0]      fourth_order_gain;
  logic [8:0]       tile_cols;
  logic [12:0]      tile_rows;
  logic [COL_W-1:0] cols_lim;
  logic [12:0]      rows_lim, cols_wide;
  logic             push, q_full, q_valid, q_pop;
  logic [QW-1:0]    push_data, q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_order_gain <= 17'd16384;
      fourth_order_gain <= 32'd268435456;
      tile_cols         <= 9'd128;
      tile_rows         <= 13'd128;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_G2:   second_order_gain <= cfg_data[16:0];
        REG_G4:   fourth_order_gain <= cfg_data;
        REG_COLS: tile_cols         <= cfg_data[8:0];
        REG_ROWS: tile_rows         <= cfg_data[12:0];
        default:  tile_cols         <= tile_cols;
      endcase
    end
  end

  // oversized geometry clamps to what the line buffers and row counter hold
  assign cols_wide = ({4'd0, tile_cols} > 13'(MAX_TILE_COLS)) ? 13'(MAX_TILE_COLS)
                                                              : {4'd0, tile_cols};
  assign cols_lim  = cols_wide[COL_W-1:0];
  assign rows_lim  = (tile_rows > 13'(ROWS_LIMIT)) ? 13'(ROWS_LIMIT) : tile_rows;

  ksr_front #(
    .MAX_TILE_COLS(MAX_TILE_COLS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .COL_W        (COL_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .cols_lim    (cols_lim),
    .rows_lim    (rows_lim),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  ksr_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (q_pop)
  );

  ksr_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .g2          (second_order_gain),
    .g4          (fourth_order_gain),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .residual    (residual),
    .last        (last)
  );

endmodule
`default_nettype wire

/* design/ksr_front.sv */
// Front end: takes samples, keeps the six line buffers and the 7x7 window,
// and queues a window snapshot for each interior point. Uses ksr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ksr_front import ksr_pkg::*; #(
  parameter int MAX_TILE_COLS = 256,
  parameter int SAMPLE_BITS   = 18,
  parameter int COL_W         = $clog2(MAX_TILE_COLS + 6)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic [COL_W-1:0]              cols_lim,
  input  wire logic [12:0]                   rows_lim,
  output logic                               push,
  output logic [CELLS*SAMPLE_BITS:0]         push_data,
  input  wire logic                          q_full
);

  localparam int SB       = SAMPLE_BITS;
  localparam int LINE_LEN = MAX_TILE_COLS + 6;

  typedef enum logic [1:0] {F_IDLE, F_READ, F_PUSH} state_t;

  state_t                 state;
  logic [COL_W-1:0]       col_pos, c_q, c_eff;
  logic [12:0]            row_pos;
  logic signed [SB-1:0]   s_q;
  logic [6*SB-1:0]        line_mem [LINE_LEN];
  logic [6*SB-1:0]        rd_word, wr_word;
  logic signed [SB-1:0]   win [CELLS];
  logic signed [SB-1:0]   col [WIN_DIM];
  logic                   last_q, accept, emit, row_end, tile_end;

  assign sample_stall = (state != F_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign c_eff        = ({1'b0, col_pos} >= (COL_W + 1)'(LINE_LEN)) ? '0 : col_pos;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      col[k] = rd_word[k*SB +: SB];
    end
    col[6] = s_q;
    for (int k = 0; k < 5; k++) begin
      wr_word[k*SB +: SB] = col[k+1];
    end
    wr_word[5*SB +: SB] = s_q;
  end

  assign row_end  = ({1'b0, c_q} >= ({1'b0, cols_lim} + (COL_W + 1)'(5)));
  assign tile_end = ({1'b0, row_pos} >= ({1'b0, rows_lim} + 14'd5));
  assign emit     = (row_pos >= 13'd6) && (c_q >= COL_W'(6));

  assign push = (state == F_PUSH) && !q_full;
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      push_data[i*SB +: SB] = win[i];
    end
    push_data[CELLS*SB] = last_q;
  end

  // line store: one row of the six buffered lines per column
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= line_mem[c_eff];
    end
    if (state == F_READ) begin
      line_mem[c_q] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      col_pos <= '0;
      row_pos <= '0;
      last_q  <= 1'b0;
      for (int i = 0; i < CELLS; i++) begin
        win[i] <= '0;
      end
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            s_q   <= sample;
            c_q   <= c_eff;
            state <= F_READ;
          end
        end
        F_READ: begin
          for (int k = 0; k < WIN_DIM; k++) begin
            for (int j = 0; j < 6; j++) begin
              win[k*WIN_DIM + j] <= win[k*WIN_DIM + j + 1];
            end
            win[k*WIN_DIM + 6] <= col[k];
          end
          last_q <= row_end && tile_end;
          if (row_end) begin
            col_pos <= '0;
            row_pos <= tile_end ? '0 : row_pos + 13'd1;
          end else begin
            col_pos <= c_q + COL_W'(1);
          end
          state <= emit ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == F_READ) && sample_stall)
    else $error("accepted sample did not start a line buffer read");

endmodule
`default_nettype wire

/* design/ksr_queue.sv */
// Two-entry queue of window snapshots between front and back end.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ksr_queue #(
  parameter int WIDTH = 883
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  q_valid,
  output logic [WIDTH-1:0]      q_data,
  input  wire logic             pop
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push |-> !full) and (pop |-> q_valid))
    else $error("queue overflow or underflow");

endmodule
`default_nettype wire

/* design/ksr_back.sv */
// Back end: runs the stencil sums on one window with a shared MAC, then the gain
// products with a 32x32 partial product multiplier, rounds and saturates. Uses ksr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ksr_back import ksr_pkg::*; #(
  parameter int SAMPLE_BITS = 18
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  input  wire logic [CELLS*SAMPLE_BITS:0]   q_data,
  output logic                              q_pop,
  input  wire logic [16:0]                  g2,
  input  wire logic [31:0]                  g4,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic signed [63:0]                residual,
  output logic                              last
);

  localparam int SB    = SAMPLE_BITS;
  localparam int ACC_W = SAMPLE_BITS + 32;

  typedef enum logic [2:0] {B_IDLE, B_MAC, B_GRAD, B_MUL, B_SUM, B_RND, B_OUT} state_t;

  state_t                  state;
  logic signed [SB-1:0]    snap [CELLS];
  logic                    last_q;
  logic [2:0]              rr, cc, part;
  logic [1:0]              sub;
  ksr_op_t                 op;
  ksr_term_t               term;
  logic signed [ACC_W-1:0] mac, acc_hyp, acc_lap, acc_gx, acc_gy;
  logic signed [63:0]      gx_r, gy_r, lap64, hyp64;
  logic [63:0]             ax, ay, lapm, hypm, t, opa, opb;
  logic                    lap_neg, hyp_neg, neg;
  logic [31:0]             ha, hb;
  logic [63:0]             pp;
  logic [127:0]            pp_sh, prod, total, lin, wsum, add_val;
  logic                    fits, load_out;

  assign q_pop = (state == B_IDLE) && q_valid;
  assign term  = ksr_term(rr, cc, sub);
  assign mac   = snap[0] * term.coef;

  assign gx_r  = (64'(acc_gx) + 64'sd2048) >>> 12;
  assign gy_r  = (64'(acc_gy) + 64'sd2048) >>> 12;
  assign lap64 = 64'(acc_lap);
  assign hyp64 = 64'(acc_hyp);

  always_comb begin
    case (op)
      OP_AXG: begin opa = ax;   opb = {47'd0, g2}; end
      OP_SQX: begin opa = t;    opb = ax;          end
      OP_AYG: begin opa = ay;   opb = {47'd0, g2}; end
      OP_SQY: begin opa = t;    opb = ay;          end
      OP_LAP: begin opa = lapm; opb = {47'd0, g2}; end
      OP_HYP: begin opa = hypm; opb = {32'd0, g4}; end
      default: begin opa = '0; opb = '0; end
    endcase
    ha = part[0] ? opa[63:32] : opa[31:0];
    hb = part[1] ? opb[63:32] : opb[31:0];
    pp = ha * hb;
    case (part[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    neg     = ((op == OP_LAP) && lap_neg) || ((op == OP_HYP) && hyp_neg);
    add_val = neg ? -prod : prod;
  end

  // saturate the rounded 49-fraction-bit sum to Q.12
  assign fits     = (&wsum[127:100]) || !(|wsum[127:100]);
  assign load_out = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
    end else begin
      // the output step reloads the register itself
      if (result_valid && !result_stall && (state != B_OUT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            for (int i = 0; i < CELLS; i++) begin
              snap[i] <= q_data[i*SB +: SB];
            end
            last_q  <= q_data[CELLS*SB];
            acc_hyp <= '0;
            acc_lap <= '0;
            acc_gx  <= '0;
            acc_gy  <= '0;
            rr      <= '0;
            cc      <= '0;
            sub     <= '0;
            state   <= B_MAC;
          end
        end
        B_MAC: begin
          case (term.tgt)
            TGT_HYP: acc_hyp <= acc_hyp + mac;
            TGT_LAP: acc_lap <= acc_lap + mac;
            TGT_GX:  acc_gx  <= acc_gx + mac;
            TGT_GY:  acc_gy  <= acc_gy + mac;
            default: acc_hyp <= acc_hyp;
          endcase
          if (term.more) begin
            sub <= sub + 2'd1;
          end else begin
            sub <= '0;
            for (int i = 0; i < CELLS - 1; i++) begin
              snap[i] <= snap[i+1];
            end
            if (cc == 3'd6) begin
              cc <= '0;
              rr <= rr + 3'd1;
              if (rr == 3'd6) begin
                state <= B_GRAD;
              end
            end else begin
              cc <= cc + 3'd1;
            end
          end
        end
        B_GRAD: begin
          ax      <= gx_r[63] ? 64'(-gx_r) : 64'(gx_r);
          ay      <= gy_r[63] ? 64'(-gy_r) : 64'(gy_r);
          lapm    <= lap64[63] ? 64'(-lap64) : 64'(lap64);
          hypm    <= hyp64[63] ? 64'(-hyp64) : 64'(hyp64);
          lap_neg <= lap64[63];
          hyp_neg <= hyp64[63];
          op      <= OP_AXG;
          part    <= '0;
          prod    <= '0;
          total   <= '0;
          lin     <= '0;
          state   <= B_MUL;
        end
        B_MUL: begin
          if (part != 3'd4) begin
            prod <= prod + pp_sh;
            part <= part + 3'd1;
          end else begin
            case (op)
              OP_AXG, OP_AYG: t     <= prod[63:0];
              OP_SQX, OP_SQY: total <= total + prod;
              default:        lin   <= lin + add_val;
            endcase
            prod <= '0;
            part <= '0;
            if (op == OP_HYP) begin
              state <= B_SUM;
            end else begin
              op <= ksr_op_t'(op + 3'd1);
            end
          end
        end
        B_SUM: begin
          wsum  <= total + {lin[114:0], 13'd0};
          state <= B_RND;
        end
        B_RND: begin
          wsum  <= wsum + (128'd1 << 36);
          state <= B_OUT;
        end
        B_OUT: begin
          if (load_out) begin
            result_valid <= 1'b1;
            last         <= last_q;
            if (fits) begin
              residual <= wsum[100:37];
            end else begin
              residual <= wsum[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == B_OUT)
    else $error("result raised outside output step");

  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    (state == B_MUL && part == 3'd4 && op == OP_HYP) |=> state == B_SUM)
    else $error("gain multiply sequence did not finish");

endmodule
`default_nettype wire

/* test/tb_ks_stencil_residual.sv */
// Testbench for ks_stencil_residual: streams haloed tiles and checks every residual.
// A built-in predictor (line store, 7x7 window, fixed-point stencil) gives the expected results.
// Depends on the design files and ksr_pkg.
`timescale 1ns / 1ps
module tb_ks_stencil_residual;
  import ksr_pkg::*;

  localparam int REG_G2    = 0;
  localparam int REG_G4    = 1;
  localparam int REG_COLS  = 2;
  localparam int REG_ROWS  = 3;
  localparam int REG_NEXT  = 4;
  localparam int REG_SPARE = 15;
  localparam int LINE_W    = 262;
  localparam int SETTLE    = 200;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int RAND_ITEMS = 750;

  typedef enum {PAT_ZERO, PAT_MAX, PAT_MIN, PAT_CHECK, PAT_RAND} pat_t;

  typedef struct {
    logic signed [63:0] res;
    logic               fin;
  } point_t;

  typedef struct {
    logic [31:0] g2;
    logic [31:0] g4;
    logic [31:0] cols;
    logic [31:0] rows;
    pat_t        pat;
  } tile_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [17:0] sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [63:0] residual;
  logic last;

  ks_stencil_residual dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall),
    .residual(residual), .last(last)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [16:0] g2_q = 17'd16384;
  logic [31:0] g4_q = 32'd268435456;
  logic [8:0]  cols_q = 9'd128;
  logic [12:0] rows_q = 13'd128;
  longint line_mem [6][LINE_W];
  longint win [7][7];
  int col_pos = 0;
  int row_pos = 0;

  point_t pending_q[$];
  int errors = 0;
  int sent = 0;
  longint cycles = 0;
  bit hold_req = 1'b0;
  bit calm = 1'b0;

  function automatic longint hyp_w(int dr, int dc);
    longint t [4][4] = '{
      '{561829610, -246065835, 47255825, -3811121},
      '{-246065835, 75497472, -7549747, 559241},
      '{47255825, -7549747, 754975, -55924},
      '{-3811121, 559241, -55924, 4143}};
    return t[dr][dc];
  endfunction

  function automatic logic signed [63:0] stencil_residual();
    longint lap_w [4] = '{-91342620, 25165824, -2516582, 186414};
    longint grad_w [4] = '{0, 12582912, -2516582, 279620};
    longint lap, hyp, gx, gy;
    logic signed [127:0] wgx, wgy, wlap, whyp, wg2, wg4, acc;
    lap = lap_w[0] * win[3][3];
    hyp = 0;
    gx = 0;
    gy = 0;
    for (int k = 1; k <= 3; k++) begin
      lap += lap_w[k] * (win[3][3-k] + win[3][3+k] + win[3-k][3] + win[3+k][3]);
      gx += grad_w[k] * (win[3][3+k] - win[3][3-k]);
      gy += grad_w[k] * (win[3+k][3] - win[3-k][3]);
    end
    for (int r = 0; r < 7; r++)
      for (int c = 0; c < 7; c++)
        hyp += hyp_w(r > 3 ? r - 3 : 3 - r, c > 3 ? c - 3 : 3 - c) * win[r][c];
    gx = (gx + 2048) >>> 12;
    gy = (gy + 2048) >>> 12;
    wgx = gx;
    wgy = gy;
    wlap = lap;
    whyp = hyp;
    wg2 = {111'b0, g2_q};
    wg4 = {96'b0, g4_q};
    acc = wg2 * (wgx * wgx + wgy * wgy) + ((wlap * wg2 + whyp * wg4) <<< 13);
    acc = (acc + (128'sd1 <<< 36)) >>> 37;
    if (acc > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (acc < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return acc[63:0];
  endfunction

  // advance the predictor by one sample; returns 1 when an interior point completes
  function automatic bit stencil_step(input logic signed [17:0] s, output point_t pt);
    int cols, rows, c, r;
    longint col [7];
    bit hit;
    cols = cols_q > 256 ? 256 : cols_q;
    rows = rows_q > ROWS_LIMIT ? ROWS_LIMIT : rows_q;
    c = col_pos >= LINE_W ? 0 : col_pos;
    r = row_pos;
    for (int k = 0; k < 6; k++) col[k] = line_mem[k][c];
    col[6] = s;
    for (int k = 0; k < 6; k++) line_mem[k][c] = col[k+1];
    for (int k = 0; k < 7; k++) begin
      for (int j = 0; j < 6; j++) win[k][j] = win[k][j+1];
      win[k][6] = col[k];
    end
    hit = (r >= 6 && c >= 6);
    if (hit) begin
      pt.res = stencil_residual();
      pt.fin = (r >= rows + 5 && c >= cols + 5);
    end
    if (c >= cols + 5) begin
      c = 0;
      r = (r >= rows + 5) ? 0 : r + 1;
    end else begin
      c++;
    end
    col_pos = c;
    row_pos = r;
    return hit;
  endfunction

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic int gap_len();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic reg_write(input int idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx[3:0];
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_G2:   g2_q = data[16:0];
      REG_G4:   g4_q = data;
      REG_COLS: cols_q = data[8:0];
      REG_ROWS: rows_q = data[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every expected residual, then let the pipeline drain
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_sample(input logic signed [17:0] v, input bit zero_typed);
    point_t pt;
    int n;
    @(negedge clk);
    sample = v;
    sample_valid = 1'b1;
    do @(posedge clk); while (sample_stall);
    sent++;
    if (stencil_step(v, pt)) begin
      if (zero_typed) pt.res = '0;
      pending_q.push_back(pt);
    end
    n = gap_len();
    if (n > 0) begin
      @(negedge clk);
      sample_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic stream_tile(input pat_t pat);
    int nc, nr;
    logic signed [17:0] v;
    nc = (cols_q > 256 ? 256 : cols_q) + 6;
    nr = (rows_q > ROWS_LIMIT ? ROWS_LIMIT : rows_q) + 6;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) begin
        case (pat)
          PAT_ZERO:  v = '0;
          PAT_MAX:   v = 18'sh1FFFF;
          PAT_MIN:   v = -18'sh20000;
          PAT_CHECK: v = ((r + c) % 2) ? 18'sh1FFFF : -18'sh20000;
          default:   v = ($urandom_range(0, 3) == 0) ? $signed(18'($urandom_range(0, 8191)) - 18'sd4096)
                                                     : 18'($urandom);
        endcase
        push_sample(v, pat == PAT_ZERO);
      end
    // no request may stay offered once the tile is done
    @(negedge clk);
    sample_valid = 1'b0;
  endtask

  task automatic set_tile(input tile_row_t t);
    drain();
    reg_write(REG_G2, t.g2);
    reg_write(REG_G4, t.g4);
    reg_write(REG_COLS, t.cols);
    reg_write(REG_ROWS, t.rows);
  endtask

  // directed tiles: gain and geometry extremes, zero-size tiles
  tile_row_t directed [] = '{
    '{32'd1, 32'd1, 32'd1, 32'd1, PAT_ZERO},
    '{32'd65536, 32'hFFFF_FFFF, 32'd2, 32'd2, PAT_MAX},
    '{32'd65536, 32'hFFFF_FFFF, 32'd2, 32'd1, PAT_MIN},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3, 32'd2, PAT_CHECK},
    '{32'd1, 32'd1, 32'd1, 32'd2, PAT_CHECK},
    '{32'd16384, 32'd268435456, 32'd0, 32'd0, PAT_RAND},
    '{32'd7, 32'd5, 32'd0, 32'd2, PAT_RAND},
    '{32'd300, 32'd9999, 32'd3, 32'd0, PAT_RAND},
    '{32'd40000, 32'd123456789, 32'd40, 32'd1, PAT_RAND},
    '{32'd2, 32'd3, 32'd1, 32'd3, PAT_RAND}
  };

  // result side: random stall, with one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall = 1'b1;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
      end
      n = gap_len();
      result_stall = (n > 0);
      if (n > 1) repeat (n - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected residual %0d", residual));
      end else begin
        want = pending_q.pop_front();
        if (residual !== want.res)
          report($sformatf("residual %0d, want %0d", residual, want.res));
        if (last !== want.fin)
          report($sformatf("last %0b, want %0b", last, want.fin));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ks_stencil_residual NOT OK");
      $finish;
    end
  end

  initial begin
    tile_row_t t;
    int goal;
    for (int k = 0; k < 6; k++)
      for (int c = 0; c < LINE_W; c++) line_mem[k][c] = 0;
    for (int k = 0; k < 7; k++)
      for (int c = 0; c < 7; c++) win[k][c] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // unused indexes must be ignored
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    reg_write(REG_NEXT, 32'h0000_0001);
    foreach (directed[i]) begin
      set_tile(directed[i]);
      stream_tile(directed[i].pat);
    end
    // receiver holds off while a tile streams in with no input gaps
    set_tile('{32'd1000, 32'd77777, 32'd6, 32'd4, PAT_RAND});
    calm = 1'b1;
    hold_req = 1'b1;
    stream_tile(PAT_RAND);
    calm = 1'b0;
    goal = sent + RAND_ITEMS;
    while (sent < goal) begin
      t.g2 = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 65536);
      t.g4 = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom;
      t.cols = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 6);
      t.rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      t.pat = PAT_RAND;
      set_tile(t);
      calm = ($urandom_range(0, 3) == 0);
      stream_tile(PAT_RAND);
    end
    calm = 1'b0;
    @(negedge clk);
    sample_valid = 1'b0;
    drain();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb_ks_stencil_residual OK");
    end else begin
      $display("tb_ks_stencil_residual NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ksr_pkg.sv
design/ksr_front.sv
design/ksr_queue.sv
design/ksr_back.sv
design/ks_stencil_residual.sv
test/tb_ks_stencil_residual.sv
